// ----- design/hsv_pkg.sv -----
package hsv_pkg;

  // Largest accepted grid dimension
  localparam int unsigned MAX_DIMENSION = 32768;

  // Header geometry and float limits
  localparam logic [4:0]  HEADER_BYTES    = 5'd24;
  localparam logic [4:0]  MAGIC_BYTES     = 5'd8;
  localparam logic [4:0]  CHUNK_BYTES     = 5'd4;
  localparam logic [31:0] FLT_MAX_BITS    = 32'h7F7F_FFFF;
  localparam logic [31:0] FLT_LOWEST_BITS = 32'hFF7F_FFFF;

  // Format mode codes
  localparam logic [1:0] MODE_AUTO  = 2'd0;
  localparam logic [1:0] MODE_RAW   = 2'd1;
  localparam logic [1:0] MODE_CHUNK = 2'd2;

  // Status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_UNKNOWN   = 4'd1;
  localparam logic [3:0] ST_CHUNKED   = 4'd2;
  localparam logic [3:0] ST_MISMATCH  = 4'd3;
  localparam logic [3:0] ST_TRUNCATED = 4'd4;
  localparam logic [3:0] ST_BAD_DIMS  = 4'd5;
  localparam logic [3:0] ST_BAD_SPACE = 4'd6;
  localparam logic [3:0] ST_SIZE      = 4'd7;
  localparam logic [3:0] ST_NONFINITE = 4'd8;

  // Result kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FINAL  = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [14:0] pos_x;
    logic [14:0] pos_y;
    logic [31:0] height_bits;
    logic [3:0]  status;
    logic [31:0] min_bits;
    logic [31:0] max_bits;
    logic [15:0] grid_width;
    logic [15:0] grid_height;
    logic [31:0] spacing_x_bits;
    logic [31:0] spacing_z_bits;
    logic        final_flag;
  } out_t;

  // Expected file magic, byte by byte; the first four also form the archive tag
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h45;
      3'd1:    r = 8'h56;
      3'd2:    r = 8'h54;
      3'd3:    r = 8'h52;
      3'd4:    r = 8'h4E;
      3'd5:    r = 8'h00;
      3'd6:    r = 8'h01;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic is_finite(input logic [31:0] v);
    return v[30:23] != 8'hFF;
  endfunction

  function automatic logic spacing_ok(input logic [31:0] v);
    return !v[31] && is_finite(v) && (v[30:0] != 31'd0);
  endfunction

  function automatic logic dims_ok(input logic [31:0] w, input logic [31:0] h);
    return (w >= 32'd1) && (w <= 32'(MAX_DIMENSION)) &&
           (h >= 32'd1) && (h <= 32'(MAX_DIMENSION));
  endfunction

  // Sign-magnitude order, minus zero equal to plus zero
  function automatic logic key_lt(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] ka;
    logic signed [32:0] kb;
    ka = a[31] ? -$signed({2'b00, a[30:0]}) : $signed({2'b00, a[30:0]});
    kb = b[31] ? -$signed({2'b00, b[30:0]}) : $signed({2'b00, b[30:0]});
    return ka < kb;
  endfunction

endpackage

// ----- design/heightfield_stream_validator_unit.sv -----
// A result is written into the result queue when the byte causing it is transferred.
// Throughput: one byte per cycle while in_stall_o is low; a file's last byte can
//   yield two results, which drain through a four-entry queue, one per cycle unless
//   out_stall_i is high. Input stalls while the queue has fewer than two free entries.
// Reset (rst_ni low, asynchronous) clears the parse state, the queue and format_mode;
//   after each last byte the parse state returns to its reset value by itself.
module heightfield_stream_validator_unit
  import hsv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i
);

  localparam int unsigned QDEPTH = 4;

  logic [1:0]  fmt_q;
  logic [4:0]  bc_q, bc_d;
  logic        hpd_q, hpd_d;
  logic        raw_ok_q, raw_ok_d;
  logic        chk_ok_q, chk_ok_d;
  logic [31:0] hw_q, hw_d;
  logic [31:0] hh_q, hh_d;
  logic [31:0] sx_q, sx_d;
  logic [31:0] sz_q, sz_d;
  logic [23:0] asm_q, asm_d;
  logic [1:0]  bis_q, bis_d;
  logic [14:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic [31:0] min_q, min_d;
  logic [31:0] max_q, max_d;
  logic        nf_q, nf_d;
  logic        exc_q, exc_d;

  out_t        q_mem_q [QDEPTH];
  logic [1:0]  head_q, tail_q;
  logic [2:0]  cnt_q;

  logic        in_acc, out_acc;
  logic [1:0]  push_n;
  out_t        res_a, res_b;

  logic [31:0] samp;
  logic        fin;
  logic [15:0] col_nx;
  logic        have8, have4, raw_d, dv, sv;
  logic [3:0]  st;
  logic [7:0]  b;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign in_stall_o  = cnt_q > 3'(QDEPTH - 2);
  assign out_valid_o = cnt_q != 3'd0;
  assign out_data_o  = q_mem_q[head_q];
  assign cfg_ready_o = 1'b1;
  assign b           = in_data_i.data_byte;

  // Hold the format register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= MODE_AUTO;
    end else if (cfg_valid_i && cfg_ready_o) begin
      fmt_q <= cfg_data_i;
    end
  end

  // Parse one byte, build the results it causes
  always_comb begin
    bc_d = bc_q; hpd_d = hpd_q; raw_ok_d = raw_ok_q; chk_ok_d = chk_ok_q;
    hw_d = hw_q; hh_d = hh_q; sx_d = sx_q; sz_d = sz_q;
    asm_d = asm_q; bis_d = bis_q; col_d = col_q; row_d = row_q;
    min_d = min_q; max_d = max_q; nf_d = nf_q; exc_d = exc_q;
    push_n = 2'd0;
    res_a  = '0;
    res_b  = '0;
    samp   = {b, asm_q};
    fin    = is_finite(samp);
    col_nx = {1'b0, col_q} + 16'd1;
    have8 = 1'b0; have4 = 1'b0; raw_d = 1'b0; dv = 1'b0; sv = 1'b0;
    st = ST_OK;

    if (in_acc) begin
      if (!hpd_q) begin
        // Header phase: magic, then byte lanes of the four header words
        case (bc_q[4:2])
          3'd0, 3'd1: begin
            if (b != magic_byte(bc_q[2:0])) raw_ok_d = 1'b0;
            if (bc_q < CHUNK_BYTES && b != magic_byte(bc_q[2:0])) chk_ok_d = 1'b0;
          end
          3'd2:    hw_d[{bc_q[1:0], 3'b000} +: 8] = b;
          3'd3:    hh_d[{bc_q[1:0], 3'b000} +: 8] = b;
          3'd4:    sx_d[{bc_q[1:0], 3'b000} +: 8] = b;
          3'd5:    sz_d[{bc_q[1:0], 3'b000} +: 8] = b;
          default: ;
        endcase
        bc_d = bc_q + 5'd1;
        if (bc_d >= HEADER_BYTES) begin
          bc_d  = HEADER_BYTES;
          hpd_d = 1'b1;
        end
      end else if (dims_ok(hw_q, hh_q) && ({16'd0, row_q} < hh_q)) begin
        if (bis_q != 2'd3) begin
          asm_d[{bis_q, 3'b000} +: 8] = b;
          bis_d = bis_q + 2'd1;
        end else begin
          asm_d = '0;
          bis_d = 2'd0;
          if (fin && !nf_q) begin
            if (key_lt(samp, min_q)) min_d = samp;
            if (key_lt(max_q, samp)) max_d = samp;
            if (fmt_q != MODE_CHUNK && raw_ok_q && spacing_ok(sx_q) && spacing_ok(sz_q)) begin
              res_a.result_kind = KIND_SAMPLE;
              res_a.pos_x       = col_q;
              res_a.pos_y       = row_q[14:0];
              res_a.height_bits = samp;
              res_a.final_flag  = !in_data_i.last;
              push_n            = 2'd1;
            end
          end
          if (!fin) nf_d = 1'b1;
          if ({16'd0, col_nx} >= hw_q) begin
            col_d = '0;
            row_d = row_q + 16'd1;
          end else begin
            col_d = col_nx[14:0];
          end
        end
      end else begin
        // Drop bytes past the grid, or all grid bytes when the dimensions are out of range
        exc_d = 1'b1;
      end

      if (in_data_i.last) begin
        // Final status in priority order
        have8 = hpd_d || (bc_d >= MAGIC_BYTES);
        have4 = hpd_d || (bc_d >= CHUNK_BYTES);
        raw_d = (fmt_q != MODE_CHUNK) && have8 && raw_ok_d;
        dv    = raw_d && hpd_d && dims_ok(hw_d, hh_d);
        sv    = raw_d && hpd_d;
        if (fmt_q == MODE_CHUNK) st = ST_CHUNKED;
        else if (!(have8 && raw_ok_d)) begin
          if (fmt_q == MODE_RAW) st = ST_MISMATCH;
          else st = (have4 && chk_ok_d) ? ST_CHUNKED : ST_UNKNOWN;
        end
        else if (!hpd_d) st = ST_TRUNCATED;
        else if (!dims_ok(hw_d, hh_d)) st = ST_BAD_DIMS;
        else if (!spacing_ok(sx_d) || !spacing_ok(sz_d)) st = ST_BAD_SPACE;
        else if (exc_d || bis_d != 2'd0 || {16'd0, row_d} != hh_d || col_d != 15'd0)
          st = ST_SIZE;
        else if (nf_d) st = ST_NONFINITE;
        else st = ST_OK;

        res_b.result_kind    = KIND_FINAL;
        res_b.status         = st;
        res_b.min_bits       = (st == ST_OK) ? min_d : 32'd0;
        res_b.max_bits       = (st == ST_OK) ? max_d : 32'd0;
        res_b.grid_width     = dv ? hw_d[15:0] : 16'd0;
        res_b.grid_height    = dv ? hh_d[15:0] : 16'd0;
        res_b.spacing_x_bits = sv ? sx_d : 32'd0;
        res_b.spacing_z_bits = sv ? sz_d : 32'd0;
        res_b.final_flag     = 1'b1;
        if (push_n == 2'd1) begin
          push_n = 2'd2;
        end else begin
          res_a  = res_b;
          push_n = 2'd1;
        end

        // Start a new file
        bc_d = '0; hpd_d = 1'b0; raw_ok_d = 1'b1; chk_ok_d = 1'b1;
        hw_d = '0; hh_d = '0; sx_d = '0; sz_d = '0;
        asm_d = '0; bis_d = '0; col_d = '0; row_d = '0;
        min_d = FLT_MAX_BITS; max_d = FLT_LOWEST_BITS; nf_d = 1'b0; exc_d = 1'b0;
      end
    end
  end

  // Hold the parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= '0; hpd_q <= 1'b0; raw_ok_q <= 1'b1; chk_ok_q <= 1'b1;
      hw_q <= '0; hh_q <= '0; sx_q <= '0; sz_q <= '0;
      asm_q <= '0; bis_q <= '0; col_q <= '0; row_q <= '0;
      min_q <= FLT_MAX_BITS; max_q <= FLT_LOWEST_BITS; nf_q <= 1'b0; exc_q <= 1'b0;
    end else begin
      bc_q <= bc_d; hpd_q <= hpd_d; raw_ok_q <= raw_ok_d; chk_ok_q <= chk_ok_d;
      hw_q <= hw_d; hh_q <= hh_d; sx_q <= sx_d; sz_q <= sz_d;
      asm_q <= asm_d; bis_q <= bis_d; col_q <= col_d; row_q <= row_d;
      min_q <= min_d; max_q <= max_d; nf_q <= nf_d; exc_q <= exc_d;
    end
  end

  // Result queue: write up to two entries, advance head on each output transfer
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) q_mem_q[tail_q] <= res_a;
    if (push_n == 2'd2) q_mem_q[tail_q + 2'd1] <= res_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      tail_q <= tail_q + push_n;
      if (out_acc) head_q <= head_q + 2'd1;
      cnt_q <= cnt_q + {1'b0, push_n} - {2'b00, out_acc};
    end
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(QDEPTH))
    else $error("result queue overflow");

  a_file_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.last |=> bc_q == 5'd0 && !hpd_q && raw_ok_q && !nf_q)
    else $error("parse state not cleared after last byte");

  a_hdr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hpd_q |-> bc_q == HEADER_BYTES)
    else $error("header done with wrong byte count");

  a_sample_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == KIND_SAMPLE |->
      out_data_o.status == ST_OK && is_finite(out_data_o.height_bits))
    else $error("sample result carries status or non-finite value");

  a_final_minmax: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == KIND_FINAL && out_data_o.status != ST_OK |->
      out_data_o.min_bits == 32'd0 && out_data_o.max_bits == 32'd0 &&
      out_data_o.final_flag)
    else $error("failed final result carries extremes");

endmodule

// ----- tb/sv/heightfield_stream_validator_unit_tb.sv -----
`timescale 1ns / 1ps

module heightfield_stream_validator_unit_tb;
  import hsv_pkg::*;

  // Register value outside the documented range; behaves as auto-detect
  localparam logic [1:0]  MODE_SPARE     = 2'd3;
  // File signature, byte 0 in the low bits
  localparam logic [63:0] FILE_SIG       = 64'h0001_004E_5254_5645;
  localparam logic [31:0] ONE_F          = 32'h3F80_0000;
  localparam logic [31:0] TWO_F          = 32'h4000_0000;
  localparam logic [31:0] POS_INF        = 32'h7F80_0000;
  localparam logic [31:0] QUIET_NAN      = 32'h7FC0_0000;
  localparam logic [31:0] NEG_ZERO       = 32'h8000_0000;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          HOLD_CYCLES    = 80;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_t        in_data_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_t       out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_data_i  = MODE_AUTO;

  // Stimulus and predicted results
  in_t        file_stream_q[$];
  out_t       grid_results_q[$];
  logic [7:0] file_buf[$];
  int         queued_bytes = 0;

  // Handshake bookkeeping
  logic byte_taken   = 1'b0;
  int   cyc          = 0;
  int   quiet_cycles = 0;
  int   hold_left    = 0;
  int   holds_done   = 0;
  int   mismatches   = 0;
  wire  calm         = (cyc >= 600) && (cyc < 1100);

  // Parser state mirrored from the block
  logic [1:0]  fmt_mode;
  int          hdr_count;
  logic        hdr_done;
  logic        tag_ok;
  logic        prefix_ok;
  logic [31:0] grid_w;
  logic [31:0] grid_h;
  logic [31:0] step_x;
  logic [31:0] step_z;
  logic [31:0] sample_acc;
  int          sample_fill;
  logic [31:0] col_idx;
  logic [31:0] row_idx;
  logic [31:0] low_height;
  logic [31:0] high_height;
  logic        bad_height_seen;
  logic        overrun;

  heightfield_stream_validator_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_parse();
    hdr_count       = 0;
    hdr_done        = 1'b0;
    tag_ok          = 1'b1;
    prefix_ok       = 1'b1;
    grid_w          = '0;
    grid_h          = '0;
    step_x          = '0;
    step_z          = '0;
    sample_acc      = '0;
    sample_fill     = 0;
    col_idx         = '0;
    row_idx         = '0;
    low_height      = FLT_MAX_BITS;
    high_height     = FLT_LOWEST_BITS;
    bad_height_seen = 1'b0;
    overrun         = 1'b0;
  endfunction

  function automatic logic grid_fits();
    return grid_w >= 1 && grid_w <= MAX_DIMENSION && grid_h >= 1 && grid_h <= MAX_DIMENSION;
  endfunction

  function automatic logic step_valid(input logic [31:0] v);
    return !v[31] && (v[30:23] != 8'hFF) && (v[30:0] != 31'd0);
  endfunction

  // Sign-magnitude order: minus zero and plus zero compare equal
  function automatic logic height_below(input logic [31:0] a, input logic [31:0] b);
    longint ka;
    longint kb;
    ka = {33'd0, a[30:0]};
    kb = {33'd0, b[30:0]};
    if (a[31]) ka = -ka;
    if (b[31]) kb = -kb;
    return ka < kb;
  endfunction

  function automatic logic tag_locked();
    return fmt_mode != MODE_CHUNK && (hdr_done || hdr_count >= 8) && tag_ok;
  endfunction

  // Advance the parser by one byte and queue the results it gives rise to
  function automatic void absorb_file_byte(input in_t it);
    logic [7:0]  b;
    logic [31:0] v;
    logic [3:0]  st;
    logic        have8;
    logic        have4;
    logic        dims_shown;
    logic        steps_shown;
    out_t        r;
    int          i;
    b = it.data_byte;
    if (!hdr_done) begin
      i = hdr_count;
      if (i < 8) begin
        if (b != FILE_SIG[8*i +: 8]) begin
          tag_ok = 1'b0;
          if (i < 4) prefix_ok = 1'b0;
        end
      end else if (i < 12) begin
        grid_w = grid_w | ({24'd0, b} << (8 * (i - 8)));
      end else if (i < 16) begin
        grid_h = grid_h | ({24'd0, b} << (8 * (i - 12)));
      end else if (i < 20) begin
        step_x = step_x | ({24'd0, b} << (8 * (i - 16)));
      end else begin
        step_z = step_z | ({24'd0, b} << (8 * (i - 20)));
      end
      hdr_count = i + 1;
      if (hdr_count >= 24) begin
        hdr_count = 24;
        hdr_done  = 1'b1;
      end
    end else if (grid_fits() && row_idx < grid_h) begin
      if (sample_fill < 3) begin
        sample_acc = sample_acc | ({24'd0, b} << (8 * sample_fill));
        sample_fill++;
      end else begin
        v           = {b, sample_acc[23:0]};
        sample_acc  = '0;
        sample_fill = 0;
        if (v[30:23] != 8'hFF && !bad_height_seen) begin
          if (height_below(v, low_height)) low_height = v;
          if (height_below(high_height, v)) high_height = v;
          if (tag_locked() && step_valid(step_x) && step_valid(step_z)) begin
            r             = '0;
            r.result_kind = KIND_SAMPLE;
            r.pos_x       = col_idx[14:0];
            r.pos_y       = row_idx[14:0];
            r.height_bits = v;
            r.final_flag  = !it.last;
            grid_results_q.push_back(r);
          end
        end
        if (v[30:23] == 8'hFF) bad_height_seen = 1'b1;
        col_idx++;
        if (col_idx >= grid_w) begin
          col_idx = '0;
          row_idx++;
        end
      end
    end else begin
      overrun = 1'b1;
    end

    if (it.last) begin
      have8 = hdr_done || hdr_count >= 8;
      have4 = hdr_done || hdr_count >= 4;
      if (fmt_mode == MODE_CHUNK) st = ST_CHUNKED;
      else if (!(have8 && tag_ok)) begin
        if (fmt_mode == MODE_RAW) st = ST_MISMATCH;
        else st = (have4 && prefix_ok) ? ST_CHUNKED : ST_UNKNOWN;
      end
      else if (!hdr_done) st = ST_TRUNCATED;
      else if (!grid_fits()) st = ST_BAD_DIMS;
      else if (!step_valid(step_x) || !step_valid(step_z)) st = ST_BAD_SPACE;
      else if (overrun || sample_fill != 0 || row_idx != grid_h || col_idx != 0) st = ST_SIZE;
      else if (bad_height_seen) st = ST_NONFINITE;
      else st = ST_OK;
      steps_shown      = tag_locked() && hdr_done;
      dims_shown       = steps_shown && grid_fits();
      r                = '0;
      r.result_kind    = KIND_FINAL;
      r.status         = st;
      r.min_bits       = (st == ST_OK) ? low_height : '0;
      r.max_bits       = (st == ST_OK) ? high_height : '0;
      r.grid_width     = dims_shown ? grid_w[15:0] : '0;
      r.grid_height    = dims_shown ? grid_h[15:0] : '0;
      r.spacing_x_bits = steps_shown ? step_x : '0;
      r.spacing_z_bits = steps_shown ? step_z : '0;
      r.final_flag     = 1'b1;
      grid_results_q.push_back(r);
      clear_parse();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // File building
  // ---------------------------------------------------------------------------

  function automatic void add_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) file_buf.push_back(w[8*k +: 8]);
  endfunction

  function automatic void add_header(input logic [31:0] w, input logic [31:0] h,
                                     input logic [31:0] sx, input logic [31:0] sz);
    for (int k = 0; k < 8; k++) file_buf.push_back(FILE_SIG[8*k +: 8]);
    add_word(w);
    add_word(h);
    add_word(sx);
    add_word(sz);
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [7:0] v;
    v = $urandom_range(0, 255);
    return v;
  endfunction

  function automatic logic [31:0] rand_height();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 39))
      0:       v[30:23] = 8'hFF;
      1:       v[30:0]  = '0;
      2:       v[30:0]  = FLT_MAX_BITS[30:0];
      3:       v[30:23] = 8'h00;
      default: ;
    endcase
    return v;
  endfunction

  function automatic void add_heights(input int n);
    repeat (n) add_word(rand_height());
  endfunction

  function automatic logic [31:0] rand_step();
    logic [31:0] v;
    v     = $urandom;
    v[31] = 1'b0;
    if (v[30:23] == 8'hFF) v[30:23] = 8'h7F;
    if (v[30:0] == 31'd0) v = ONE_F;
    return v;
  endfunction

  function automatic logic [31:0] rand_bad_step();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 4))
      0:       v = '0;
      1:       v = NEG_ZERO;
      2:       v = POS_INF | {v[31], 31'd0};
      3:       v = QUIET_NAN | {v[31], 8'd0, v[22:0]};
      default: begin
        v[31] = 1'b1;
        if (v[30:23] == 8'hFF) v[30:23] = 8'h80;
      end
    endcase
    return v;
  endfunction

  // Hand the built file to the driver, flagging its final byte
  function automatic void commit_file();
    in_t it;
    foreach (file_buf[k]) begin
      it.data_byte = file_buf[k];
      it.last      = (k == file_buf.size() - 1);
      file_stream_q.push_back(it);
    end
    queued_bytes += file_buf.size();
    file_buf.delete();
  endfunction

  // Mostly complete small grids with random content; the rest broken on purpose
  function automatic void queue_random_file();
    int          pick;
    int          w;
    int          h;
    int          k;
    logic [31:0] sx;
    logic [31:0] sz;
    logic [31:0] odd;
    pick = $urandom_range(0, 99);
    w    = $urandom_range(1, 4);
    h    = $urandom_range(1, 4);
    sx   = rand_step();
    sz   = rand_step();
    if (pick < 70) begin
      add_header(w, h, sx, sz);
      add_heights(w * h);
    end else if (pick < 76) begin
      // cut short somewhere in the header or the grid
      add_header(w, h, sx, sz);
      add_heights(w * h);
      k = $urandom_range(1, file_buf.size() - 1);
      while (file_buf.size() > k) file_buf.delete(file_buf.size() - 1);
    end else if (pick < 82) begin
      // trailing bytes past the grid
      add_header(w, h, sx, sz);
      add_heights(w * h);
      repeat ($urandom_range(1, 6)) file_buf.push_back(rand_byte());
    end else if (pick < 86) begin
      if ($urandom_range(0, 1)) begin
        // one signature bit flipped
        add_header(w, h, sx, sz);
        add_heights(w * h);
        k = $urandom_range(0, 7);
        file_buf[k] = file_buf[k] ^ (8'h01 << $urandom_range(0, 7));
      end else begin
        // archive prefix followed by junk
        for (int j = 0; j < 4; j++) file_buf.push_back(FILE_SIG[8*j +: 8]);
        repeat ($urandom_range(0, 12)) file_buf.push_back(rand_byte());
      end
    end else if (pick < 90) begin
      // dimension out of range
      case ($urandom_range(0, 2))
        0:       odd = '0;
        1:       odd = MAX_DIMENSION + 1;
        default: odd = $urandom;
      endcase
      if ($urandom_range(0, 1)) add_header(odd, h, sx, sz);
      else add_header(w, odd, sx, sz);
      repeat ($urandom_range(0, 8)) file_buf.push_back(rand_byte());
    end else if (pick < 94) begin
      if ($urandom_range(0, 1)) sx = rand_bad_step();
      else sz = rand_bad_step();
      add_header(w, h, sx, sz);
      add_heights(w * h);
    end else if (pick < 96) begin
      // largest dimensions, only a few samples sent
      case ($urandom_range(0, 2))
        0:       add_header(MAX_DIMENSION, h, sx, sz);
        1:       add_header(w, MAX_DIMENSION, sx, sz);
        default: add_header(MAX_DIMENSION, MAX_DIMENSION, sx, sz);
      endcase
      add_heights($urandom_range(0, 6));
    end else begin
      repeat ($urandom_range(1, 40)) file_buf.push_back(rand_byte());
    end
    commit_file();
  endfunction

  function automatic void queue_random_bytes(input int budget);
    int start;
    start = queued_bytes;
    while (queued_bytes - start < budget) queue_random_file();
  endfunction

  // ---------------------------------------------------------------------------
  // Phase control
  // ---------------------------------------------------------------------------

  task automatic drain();
    @(posedge clk_i);
    while (file_stream_q.size() != 0 || in_valid_i || grid_results_q.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic set_mode(input logic [1:0] m);
    drain();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_data_i  <= m;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    fmt_mode = m;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic string result_text(input out_t r);
    return $sformatf("kind=%0d x=%0d y=%0d h=%h st=%0d min=%h max=%h grid=%0dx%0d sx=%h sz=%h fin=%0d",
                     r.result_kind, r.pos_x, r.pos_y, r.height_bits, r.status, r.min_bits,
                     r.max_bits, r.grid_width, r.grid_height, r.spacing_x_bits,
                     r.spacing_z_bits, r.final_flag);
  endfunction

  initial begin
    clear_parse();
    fmt_mode = MODE_AUTO;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Auto-detect after reset: well-formed grids
    add_header(1, 1, ONE_F, ONE_F);
    add_word(32'h0);
    commit_file();
    // float range extremes, minus zero ahead of plus zero
    add_header(2, 2, 32'h0000_0001, FLT_MAX_BITS);
    add_word(NEG_ZERO);
    add_word(32'h0);
    add_word(FLT_MAX_BITS);
    add_word(FLT_LOWEST_BITS);
    commit_file();
    // non-finite height suppresses the samples after it
    add_header(3, 1, ONE_F, TWO_F);
    add_word(ONE_F);
    add_word(POS_INF);
    add_word(TWO_F);
    commit_file();
    // archive prefix, too-short prefix, single byte
    for (int j = 0; j < 4; j++) file_buf.push_back(FILE_SIG[8*j +: 8]);
    file_buf.push_back(8'hFF);
    file_buf.push_back(8'h00);
    commit_file();
    for (int j = 0; j < 3; j++) file_buf.push_back(FILE_SIG[8*j +: 8]);
    commit_file();
    file_buf.push_back(8'hFF);
    commit_file();
    // header ends early
    add_header(1, 1, ONE_F, ONE_F);
    while (file_buf.size() > 18) file_buf.delete(file_buf.size() - 1);
    commit_file();
    // dimensions: zero, one past the limit, all ones, largest grid cut short
    add_header(0, 1, ONE_F, ONE_F);
    add_word(ONE_F);
    commit_file();
    add_header(1, MAX_DIMENSION + 1, ONE_F, ONE_F);
    commit_file();
    add_header(32'hFFFF_FFFF, 1, ONE_F, ONE_F);
    commit_file();
    add_header(MAX_DIMENSION, MAX_DIMENSION, ONE_F, ONE_F);
    add_word(ONE_F);
    add_word(TWO_F);
    commit_file();
    // spacings: minus zero, zero, infinity, NaN
    add_header(1, 1, NEG_ZERO, ONE_F);
    add_word(ONE_F);
    commit_file();
    add_header(1, 1, ONE_F, 32'h0);
    add_word(ONE_F);
    commit_file();
    add_header(1, 1, POS_INF, ONE_F);
    add_word(ONE_F);
    commit_file();
    add_header(1, 1, ONE_F, QUIET_NAN);
    add_word(ONE_F);
    commit_file();
    // size: a row missing, bytes past the grid, a half-built sample
    add_header(1, 2, ONE_F, ONE_F);
    add_word(ONE_F);
    commit_file();
    add_header(1, 1, ONE_F, ONE_F);
    add_word(ONE_F);
    file_buf.push_back(8'h12);
    file_buf.push_back(8'h34);
    commit_file();
    add_header(1, 1, ONE_F, ONE_F);
    file_buf.push_back(8'h12);
    file_buf.push_back(8'h34);
    commit_file();

    // Forced raw: signature failures report a mismatch
    set_mode(MODE_RAW);
    add_header(1, 1, ONE_F, ONE_F);
    add_word(ONE_F);
    file_buf[0] = 8'h00;
    commit_file();
    file_buf.push_back(FILE_SIG[7:0]);
    file_buf.push_back(FILE_SIG[15:8]);
    commit_file();
    add_header(2, 1, ONE_F, ONE_F);
    add_heights(2);
    commit_file();
    queue_random_bytes(250);

    // Forced archive: no samples, status only
    set_mode(MODE_CHUNK);
    add_header(2, 1, ONE_F, ONE_F);
    add_heights(2);
    commit_file();
    queue_random_bytes(170);

    set_mode(MODE_SPARE);
    queue_random_bytes(170);

    set_mode(MODE_AUTO);
    queue_random_bytes(530);

    drain();
    repeat (20) @(posedge clk_i);
    if (grid_results_q.size() != 0)
      $display("%0d predicted results never arrived", grid_results_q.size());
    if (mismatches == 0 && grid_results_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver, receiver and checker
  // ---------------------------------------------------------------------------

  // Record the input transfer and predict its results
  always @(posedge clk_i) begin
    byte_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) absorb_file_byte(in_data_i);
  end

  // Offer the next byte once the previous one has gone; hold a stalled one
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || byte_taken)) begin
      if (file_stream_q.size() != 0 && (calm || $urandom_range(0, 99) >= 33)) begin
        in_data_i  <= file_stream_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Stall results at random, with two long hold-offs to back the block up;
  // each starts only while plenty of bytes are still waiting to be sent
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (holds_done < 2 && cyc >= 1000 * (holds_done + 1) &&
                 file_stream_q.size() > 40) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      holds_done  <= holds_done + 1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(0, 99) < 33);
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (grid_results_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result: %s", result_text(out_data_o));
      end else begin
        want = grid_results_q.pop_front();
        if (out_data_o !== want) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("result mismatch\n  expected %s\n  actual   %s",
                     result_text(want), result_text(out_data_o));
        end
      end
    end
  end

  // Abort when no transfer of any kind happens for too long
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
